// ===== src/union_find_and_cost_assert.svh =====
// Assertion macros shared by the disjoint-set engine.
`ifndef UNION_FIND_AND_COST_ASSERT_SVH
`define UNION_FIND_AND_COST_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define UFC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UFC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define UFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/ufc_pkg.sv =====
`default_nettype none

package ufc_pkg;

  localparam int NODE_IN_BITS = 10;
  localparam int WEIGHT_BITS  = 32;
  localparam int RANK_BITS    = 4;
  localparam int INFO_BITS    = RANK_BITS + WEIGHT_BITS;
  localparam int KIND_BITS    = 2;
  localparam int RECIP_SHIFT  = 20;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [RANK_BITS-1:0]   RANK_ZERO   = '0;
  localparam logic [RANK_BITS-1:0]   RANK_ONE    = 1;
  localparam logic [RANK_BITS-1:0]   RANK_MAX    = '1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONES = '1;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ZERO = '0;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_EDGE,
    KIND_QUERY,
    KIND_SAME
  } item_kind_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FRD,
    B_FCK,
    B_CRD,
    B_CCK,
    B_JOIN,
    B_JOIN2
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== src/ufc_ram.sv =====
`default_nettype none

module ufc_ram #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ufc_front.sv =====
`default_nettype none

`include "union_find_and_cost_assert.svh"

module ufc_front #(
  parameter int NODES   = 1024,
  parameter int NW      = $clog2(NODES),
  parameter int ENTRY_W = ufc_pkg::KIND_BITS + 2 * NW + ufc_pkg::WEIGHT_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic                                cmd,
  input  wire logic [ufc_pkg::NODE_IN_BITS-1:0]    node_a,
  input  wire logic [ufc_pkg::NODE_IN_BITS-1:0]    node_b,
  input  wire logic [ufc_pkg::WEIGHT_BITS-1:0]     weight,
  input  wire logic                                clearing,
  input  wire ufc_pkg::queue_stat_t                q_stat,
  output logic                                     busy,
  output logic                                     push,
  output logic      [ENTRY_W-1:0]                  push_data
);

  localparam int NIB    = ufc_pkg::NODE_IN_BITS;
  localparam int PROD_W = NIB + ufc_pkg::RECIP_SHIFT;
  localparam int CMP_W  = 18;
  localparam logic [PROD_W-1:0] RECIP   = PROD_W'((1 << ufc_pkg::RECIP_SHIFT) / NODES);
  localparam logic [CMP_W-1:0]  NODES_C = CMP_W'(NODES);

  logic                               accept;
  logic                               s1_valid;
  logic                               s1_cmd;
  logic [NIB-1:0]                     s1_a;
  logic [NIB-1:0]                     s1_b;
  logic [ufc_pkg::WEIGHT_BITS-1:0]    s1_w;
  logic [PROD_W-1:0]                  s1_pa;
  logic [PROD_W-1:0]                  s1_pb;
  logic [NW-1:0]                      idx_a;
  logic [NW-1:0]                      idx_b;
  ufc_pkg::item_kind_t                kind;

  // The quotient estimate from the reciprocal is at most one short, so a
  // single compare and subtract finishes the reduction.
  function automatic logic [NW-1:0] reduce(input logic [NIB-1:0] v,
                                           input logic [PROD_W-1:0] p);
    logic [NIB-1:0]    q;
    logic [PROD_W-1:0] qn;
    logic [CMP_W-1:0]  r;
    q  = p[PROD_W-1:ufc_pkg::RECIP_SHIFT];
    qn = PROD_W'(q) * PROD_W'(NODES);
    r  = CMP_W'(v - qn[NIB-1:0]);
    if (r >= NODES_C) begin
      r = r - NODES_C;
    end
    return r[NW-1:0];
  endfunction

  assign busy   = s1_valid || clearing;
  assign accept = start && !busy;
  assign push   = s1_valid && !q_stat.full;

  always_comb begin
    idx_a = reduce(s1_a, s1_pa);
    idx_b = reduce(s1_b, s1_pb);
    if (s1_cmd == ufc_pkg::CMD_EDGE) begin
      kind = ufc_pkg::KIND_EDGE;
    end else if (idx_a == idx_b) begin
      kind = ufc_pkg::KIND_SAME;
    end else begin
      kind = ufc_pkg::KIND_QUERY;
    end
    push_data = {kind, idx_a, idx_b, s1_w};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= cmd;
      s1_a   <= node_a;
      s1_b   <= node_b;
      s1_w   <= weight;
      s1_pa  <= PROD_W'(node_a) * RECIP;
      s1_pb  <= PROD_W'(node_b) * RECIP;
    end
  end

  `UFC_ASSERT_NEXT(a_front_hold, clk, rst, accept, s1_valid && busy, "accepted word not held in the front stage")
  `UFC_ASSERT_NOW(a_front_no_push_clear, clk, rst, clearing, !accept, "word accepted during the clearing pass")

endmodule

`default_nettype wire

// ===== src/ufc_queue.sv =====
`default_nettype none

`include "union_find_and_cost_assert.svh"

module ufc_queue #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [WIDTH-1:0]   push_data,
  input  wire logic               pop,
  output logic      [WIDTH-1:0]   pop_data,
  output ufc_pkg::queue_stat_t    stat
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign stat.full  = (count == (PW + 1)'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `UFC_ASSERT_NOW(a_queue_no_overflow, clk, rst, push, !stat.full || pop, "word pushed into a full queue")
  `UFC_ASSERT_NOW(a_queue_no_underflow, clk, rst, pop, !stat.empty, "word popped from an empty queue")

endmodule

`default_nettype wire

// ===== src/ufc_back.sv =====
`default_nettype none

`include "union_find_and_cost_assert.svh"

module ufc_back #(
  parameter int NODES   = 1024,
  parameter int NW      = $clog2(NODES),
  parameter int ENTRY_W = ufc_pkg::KIND_BITS + 2 * NW + ufc_pkg::WEIGHT_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ufc_pkg::queue_stat_t              q_stat,
  input  wire logic [ENTRY_W-1:0]                pop_data,
  output logic                                   pop,
  output logic                                   clearing,
  output logic                                   valid,
  output logic      [ufc_pkg::WEIGHT_BITS-1:0]   walk_cost,
  output logic                                   reachable
);

  localparam int WB     = ufc_pkg::WEIGHT_BITS;
  localparam int RB     = ufc_pkg::RANK_BITS;
  localparam int INFO_W = ufc_pkg::INFO_BITS;
  localparam int NODE_W = NW + INFO_W;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

  ufc_pkg::back_state_t state, state_next;
  ufc_pkg::item_kind_t  kind, kind_next;

  logic [NW-1:0]     cur, cur_next;
  logic [NW-1:0]     xn, xn_next;
  logic              phase, phase_next;
  logic [NW-1:0]     root_a, root_a_next;
  logic [NW-1:0]     root_b, root_b_next;
  logic [INFO_W-1:0] ra_info, ra_info_next;
  logic [INFO_W-1:0] rb_info, rb_info_next;
  logic [NW-1:0]     a_r, a_r_next;
  logic [NW-1:0]     b_r, b_r_next;
  logic [WB-1:0]     w_r, w_r_next;
  logic [NW-1:0]     wr2_addr, wr2_addr_next;
  logic [NODE_W-1:0] wr2_data, wr2_data_next;
  logic [NW-1:0]     clr_cnt, clr_cnt_next;
  logic              valid_next;
  logic [WB-1:0]     walk_cost_next;
  logic              reachable_next;

  logic              we;
  logic [NW-1:0]     waddr;
  logic [NODE_W-1:0] wdata;
  logic [NW-1:0]     raddr;
  logic [NODE_W-1:0] rdata;

  logic [NW-1:0]     rd_parent;
  logic [INFO_W-1:0] rd_info;
  logic [NW-1:0]     root_sel;
  logic [RB-1:0]     ra_rank;
  logic [RB-1:0]     rb_rank;
  logic [RB-1:0]     rank_up;
  logic [WB-1:0]     ra_cost;
  logic [WB-1:0]     rb_cost;
  logic [WB-1:0]     joined_cost;

  // Each word holds a node's parent, rank and component cost.
  ufc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES),
    .AW    (NW)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_parent   = rdata[NODE_W-1 -: NW];
  assign rd_info     = rdata[INFO_W-1:0];
  assign root_sel    = phase ? root_b : root_a;
  assign ra_rank     = ra_info[INFO_W-1 -: RB];
  assign rb_rank     = rb_info[INFO_W-1 -: RB];
  assign ra_cost     = ra_info[WB-1:0];
  assign rb_cost     = rb_info[WB-1:0];
  assign joined_cost = ra_cost & rb_cost & w_r;
  assign clearing    = (state == ufc_pkg::B_CLEAR);

  always_comb begin
    if (ra_rank == rb_rank && ra_rank != ufc_pkg::RANK_MAX) begin
      rank_up = ra_rank + ufc_pkg::RANK_ONE;
    end else begin
      rank_up = ra_rank;
    end
  end

  always_comb begin
    state_next     = state;
    kind_next      = kind;
    cur_next       = cur;
    xn_next        = xn;
    phase_next     = phase;
    root_a_next    = root_a;
    root_b_next    = root_b;
    ra_info_next   = ra_info;
    rb_info_next   = rb_info;
    a_r_next       = a_r;
    b_r_next       = b_r;
    w_r_next       = w_r;
    wr2_addr_next  = wr2_addr;
    wr2_data_next  = wr2_data;
    clr_cnt_next   = clr_cnt;
    valid_next     = 1'b0;
    walk_cost_next = walk_cost;
    reachable_next = reachable;
    we             = 1'b0;
    waddr          = cur;
    wdata          = '0;
    raddr          = cur;
    pop            = 1'b0;

    case (state)
      ufc_pkg::B_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_cnt;
        wdata        = {clr_cnt, ufc_pkg::RANK_ZERO, ufc_pkg::WEIGHT_ONES};
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST_NODE) begin
          state_next = ufc_pkg::B_IDLE;
        end
      end
      ufc_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          kind_next = ufc_pkg::item_kind_t'(pop_data[ENTRY_W-1 -: ufc_pkg::KIND_BITS]);
          a_r_next  = pop_data[2 * NW + WB - 1 -: NW];
          b_r_next  = pop_data[NW + WB - 1 -: NW];
          w_r_next  = pop_data[WB-1:0];
          if (kind_next == ufc_pkg::KIND_SAME) begin
            valid_next     = 1'b1;
            walk_cost_next = ufc_pkg::WEIGHT_ZERO;
            reachable_next = 1'b1;
          end else begin
            cur_next   = a_r_next;
            phase_next = 1'b0;
            state_next = ufc_pkg::B_FRD;
          end
        end
      end
      ufc_pkg::B_FRD: begin
        raddr      = cur;
        state_next = ufc_pkg::B_FCK;
      end
      ufc_pkg::B_FCK: begin
        if (rd_parent == cur) begin
          if (phase) begin
            root_b_next  = cur;
            rb_info_next = rd_info;
            xn_next      = b_r;
          end else begin
            root_a_next  = cur;
            ra_info_next = rd_info;
            xn_next      = a_r;
          end
          state_next = ufc_pkg::B_CRD;
        end else begin
          cur_next   = rd_parent;
          state_next = ufc_pkg::B_FRD;
        end
      end
      ufc_pkg::B_CRD: begin
        raddr      = xn;
        state_next = ufc_pkg::B_CCK;
      end
      ufc_pkg::B_CCK: begin
        // Second walk: point every node on the path straight at the root.
        if (rd_parent == root_sel) begin
          if (phase) begin
            state_next = ufc_pkg::B_JOIN;
          end else begin
            phase_next = 1'b1;
            cur_next   = b_r;
            state_next = ufc_pkg::B_FRD;
          end
        end else begin
          we         = 1'b1;
          waddr      = xn;
          wdata      = {root_sel, rd_info};
          xn_next    = rd_parent;
          state_next = ufc_pkg::B_CRD;
        end
      end
      ufc_pkg::B_JOIN: begin
        state_next = ufc_pkg::B_IDLE;
        if (kind == ufc_pkg::KIND_QUERY) begin
          valid_next = 1'b1;
          if (root_a == root_b) begin
            walk_cost_next = ra_cost;
            reachable_next = 1'b1;
          end else begin
            walk_cost_next = ufc_pkg::WEIGHT_ONES;
            reachable_next = 1'b0;
          end
        end else if (root_a == root_b) begin
          we    = 1'b1;
          waddr = root_a;
          wdata = {root_a, ra_rank, ra_cost & w_r};
        end else if (ra_rank < rb_rank) begin
          we            = 1'b1;
          waddr         = root_a;
          wdata         = {root_b, ra_info};
          wr2_addr_next = root_b;
          wr2_data_next = {root_b, rb_rank, joined_cost};
          state_next    = ufc_pkg::B_JOIN2;
        end else begin
          we            = 1'b1;
          waddr         = root_b;
          wdata         = {root_a, rb_info};
          wr2_addr_next = root_a;
          wr2_data_next = {root_a, rank_up, joined_cost};
          state_next    = ufc_pkg::B_JOIN2;
        end
      end
      ufc_pkg::B_JOIN2: begin
        we         = 1'b1;
        waddr      = wr2_addr;
        wdata      = wr2_data;
        state_next = ufc_pkg::B_IDLE;
      end
      default: begin
        state_next = ufc_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ufc_pkg::B_CLEAR;
      clr_cnt <= '0;
      valid   <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      valid   <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind      <= kind_next;
    cur       <= cur_next;
    xn        <= xn_next;
    phase     <= phase_next;
    root_a    <= root_a_next;
    root_b    <= root_b_next;
    ra_info   <= ra_info_next;
    rb_info   <= rb_info_next;
    a_r       <= a_r_next;
    b_r       <= b_r_next;
    w_r       <= w_r_next;
    wr2_addr  <= wr2_addr_next;
    wr2_data  <= wr2_data_next;
    walk_cost <= walk_cost_next;
    reachable <= reachable_next;
  end

  `UFC_ASSERT_NOW(a_back_unreach_ones, clk, rst, valid && !reachable, walk_cost == ufc_pkg::WEIGHT_ONES, "unreachable result without all-ones cost")
  `UFC_ASSERT_NOW(a_back_write_state, clk, rst, we, state != ufc_pkg::B_IDLE && state != ufc_pkg::B_FRD && state != ufc_pkg::B_CRD, "node table written outside a writing step")
  `UFC_ASSERT_NEXT(a_back_join_two, clk, rst, state == ufc_pkg::B_JOIN && kind == ufc_pkg::KIND_EDGE && root_a != root_b, state == ufc_pkg::B_JOIN2, "join of two roots did not take its second write")

endmodule

`default_nettype wire

// ===== src/union_find_and_cost.sv =====
`default_nettype none

`include "union_find_and_cost_assert.svh"

// Disjoint-set engine with a component AND-cost per root. A word is taken
// when start is high and busy is low; an edge gives no result, a query
// gives one result, shown on walk_cost and reachable for the single cycle
// in which valid is high, and it must be caught then, as the block cannot
// be held off. After reset the node table is swept once, one node per
// cycle, and busy stays high until the sweep is through. The front stage
// registers each word it takes and holds it (index reduction and
// classification) until the two-entry queue has room; it takes no new word
// while it holds one, and the queue lets a new word be taken while the
// back end works. The back end runs on the single port pair of the node
// memory: a query on equal nodes is answered straight from the queue; any
// other word leaves the queue, then the root of each node is searched and
// its path compressed in turn, and last the result is given or the join
// written, with a second write when two roots are joined; union by rank
// keeps the paths short.
module union_find_and_cost #(
  parameter int NODES = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cmd,
  input  wire logic [ufc_pkg::NODE_IN_BITS-1:0]  node_a,
  input  wire logic [ufc_pkg::NODE_IN_BITS-1:0]  node_b,
  input  wire logic [ufc_pkg::WEIGHT_BITS-1:0]   weight,
  output logic                                   valid,
  output logic      [ufc_pkg::WEIGHT_BITS-1:0]   walk_cost,
  output logic                                   reachable
);

  localparam int NW      = $clog2(NODES);
  localparam int ENTRY_W = ufc_pkg::KIND_BITS + 2 * NW + ufc_pkg::WEIGHT_BITS;

  logic                 clearing;
  logic                 push;
  logic [ENTRY_W-1:0]   push_data;
  logic                 pop;
  logic [ENTRY_W-1:0]   pop_data;
  ufc_pkg::queue_stat_t q_stat;

  ufc_front #(
    .NODES   (NODES),
    .NW      (NW),
    .ENTRY_W (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .node_a    (node_a),
    .node_b    (node_b),
    .weight    (weight),
    .clearing  (clearing),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  ufc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (ufc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  ufc_back #(
    .NODES   (NODES),
    .NW      (NW),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .clearing  (clearing),
    .valid     (valid),
    .walk_cost (walk_cost),
    .reachable (reachable)
  );

  `UFC_ASSERT_NOW(a_top_busy_clear, clk, rst, clearing, busy && !valid, "block open or reporting during the clearing pass")

endmodule

`default_nettype wire

// ===== verif/union_find_and_cost_tb.sv =====
`timescale 1ns / 100ps

module union_find_and_cost_tb;

  localparam int NODE_COUNT   = 1024;
  localparam int RANDOM_WORDS = 380;
  localparam int TAIL_WORDS   = 60;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int SHOWN_ERRORS = 10;

  typedef struct {
    logic                             cmd;
    logic [ufc_pkg::NODE_IN_BITS-1:0] node_a;
    logic [ufc_pkg::NODE_IN_BITS-1:0] node_b;
    logic [ufc_pkg::WEIGHT_BITS-1:0]  weight;
  } uf_word_t;

  typedef struct {
    logic [ufc_pkg::WEIGHT_BITS-1:0] walk_cost;
    logic                            reachable;
  } walk_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             cmd = ufc_pkg::CMD_EDGE;
  logic [ufc_pkg::NODE_IN_BITS-1:0] node_a = '0;
  logic [ufc_pkg::NODE_IN_BITS-1:0] node_b = '0;
  logic [ufc_pkg::WEIGHT_BITS-1:0]  weight = '0;
  logic                             busy;
  logic                             valid;
  logic [ufc_pkg::WEIGHT_BITS-1:0]  walk_cost;
  logic                             reachable;

  uf_word_t     pending_words[$];
  walk_result_t expected_walks[$];

  logic [ufc_pkg::NODE_IN_BITS-1:0] parent_of[NODE_COUNT];
  logic [ufc_pkg::RANK_BITS-1:0]    rank_of[NODE_COUNT];
  logic [ufc_pkg::WEIGHT_BITS-1:0]  cost_of[NODE_COUNT];

  uf_word_t in_flight;
  int       idle_left = 0;
  int       sent_words = 0;
  int       mismatch_count = 0;
  int       stall_cycles = 0;

  union_find_and_cost #(
    .NODES(NODE_COUNT)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .node_a    (node_a),
    .node_b    (node_b),
    .weight    (weight),
    .valid     (valid),
    .walk_cost (walk_cost),
    .reachable (reachable)
  );

  always #2 clk = ~clk;

  // Root search with path compression on the shadow node table.
  function automatic logic [ufc_pkg::NODE_IN_BITS-1:0] find_root_of(
      input logic [ufc_pkg::NODE_IN_BITS-1:0] n);
    logic [ufc_pkg::NODE_IN_BITS-1:0] root;
    logic [ufc_pkg::NODE_IN_BITS-1:0] walk;
    logic [ufc_pkg::NODE_IN_BITS-1:0] next_hop;
    root = n;
    while (parent_of[root] != root) root = parent_of[root];
    walk = n;
    while (parent_of[walk] != root) begin
      next_hop = parent_of[walk];
      parent_of[walk] = root;
      walk = next_hop;
    end
    return root;
  endfunction

  // Applies one accepted word to the shadow tables and queues the walk it reports.
  task automatic apply_word(input uf_word_t w);
    logic [ufc_pkg::NODE_IN_BITS-1:0] a;
    logic [ufc_pkg::NODE_IN_BITS-1:0] b;
    logic [ufc_pkg::NODE_IN_BITS-1:0] root_a;
    logic [ufc_pkg::NODE_IN_BITS-1:0] root_b;
    logic [ufc_pkg::NODE_IN_BITS-1:0] keep;
    walk_result_t                     res;
    a = ufc_pkg::NODE_IN_BITS'(w.node_a % NODE_COUNT);
    b = ufc_pkg::NODE_IN_BITS'(w.node_b % NODE_COUNT);
    if (w.cmd == ufc_pkg::CMD_EDGE) begin
      root_a = find_root_of(a);
      root_b = find_root_of(b);
      keep = root_a;
      if (root_a != root_b) begin
        if (rank_of[root_a] < rank_of[root_b]) begin
          parent_of[root_a] = root_b;
          cost_of[root_b] &= cost_of[root_a];
          keep = root_b;
        end else begin
          if (rank_of[root_a] == rank_of[root_b] && rank_of[root_a] != ufc_pkg::RANK_MAX)
            rank_of[root_a] = rank_of[root_a] + ufc_pkg::RANK_ONE;
          parent_of[root_b] = root_a;
          cost_of[root_a] &= cost_of[root_b];
        end
      end
      cost_of[keep] &= w.weight;
    end else begin
      if (a == b) begin
        res.walk_cost = ufc_pkg::WEIGHT_ZERO;
        res.reachable = 1'b1;
      end else begin
        root_a = find_root_of(a);
        root_b = find_root_of(b);
        if (root_a != root_b) begin
          res.walk_cost = ufc_pkg::WEIGHT_ONES;
          res.reachable = 1'b0;
        end else begin
          res.walk_cost = cost_of[root_a];
          res.reachable = 1'b1;
        end
      end
      expected_walks.insert(expected_walks.size(), res);
    end
  endtask

  task automatic queue_word(input logic c, input int a, input int b, input logic [31:0] w);
    uf_word_t item;
    item.cmd = c;
    item.node_a = ufc_pkg::NODE_IN_BITS'(a);
    item.node_b = ufc_pkg::NODE_IN_BITS'(b);
    item.weight = w;
    pending_words.insert(pending_words.size(), item);
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Driver: a word stays on the ports until busy is seen low at a rising edge.
  always @(posedge clk) begin : drive_words
    bit idle_allowed;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) apply_word(in_flight);
      // Every third stretch of forty words runs without gaps, as does the tail.
      idle_allowed = ((sent_words / 40) % 3 != 2) && pending_words.size() > TAIL_WORDS;
      if (idle_left == 0 && idle_allowed && $urandom_range(0, 5) == 0)
        idle_left = $urandom_range(1, 8);
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_flight = pending_words.pop_front();
        sent_words++;
        start  <= 1'b1;
        cmd    <= in_flight.cmd;
        node_a <= in_flight.node_a;
        node_b <= in_flight.node_b;
        weight <= in_flight.weight;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked as it passes.
  always @(posedge clk) begin : check_walks
    walk_result_t want;
    if (!rst && valid) begin
      if (expected_walks.size() == 0) begin
        note_mismatch($sformatf("unexpected result cost=%h reachable=%b", walk_cost, reachable));
      end else begin
        want = expected_walks.pop_front();
        if (walk_cost !== want.walk_cost)
          note_mismatch($sformatf("walk_cost expected %h got %h", want.walk_cost, walk_cost));
        if (reachable !== want.reachable)
          note_mismatch($sformatf("reachable expected %b got %b", want.reachable, reachable));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("union_find_and_cost_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int          pool_base;
    int          pool_size;
    int          a;
    int          b;
    int          pick;
    logic [31:0] w;
    for (int i = 0; i < NODE_COUNT; i++) begin
      parent_of[i] = ufc_pkg::NODE_IN_BITS'(i);
      rank_of[i] = ufc_pkg::RANK_ZERO;
      cost_of[i] = ufc_pkg::WEIGHT_ONES;
    end

    // Directed opening: same node, unconnected, joins of equal and unequal rank,
    // self-loops and the weight extremes.
    queue_word(ufc_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF);
    queue_word(ufc_pkg::CMD_QUERY, 1023, 1023, 32'h0);
    queue_word(ufc_pkg::CMD_QUERY, 0, 1023, 32'h1234_5678);
    queue_word(ufc_pkg::CMD_EDGE, 0, 1, 32'hFFFF_FFFF);
    queue_word(ufc_pkg::CMD_QUERY, 1, 0, 32'h0);
    queue_word(ufc_pkg::CMD_EDGE, 2, 3, 32'hFFFF_0000);
    queue_word(ufc_pkg::CMD_EDGE, 3, 1, 32'hFFFF_FFF7);
    queue_word(ufc_pkg::CMD_EDGE, 4, 2, 32'hAAAA_AAAA | 32'h8000_0001);
    queue_word(ufc_pkg::CMD_QUERY, 4, 0, 32'hFFFF_FFFF);
    queue_word(ufc_pkg::CMD_EDGE, 5, 5, 32'hFFFF_FFFE);
    queue_word(ufc_pkg::CMD_QUERY, 5, 5, 32'h0);
    queue_word(ufc_pkg::CMD_QUERY, 5, 6, 32'h0);
    queue_word(ufc_pkg::CMD_EDGE, 5, 6, 32'h7FFF_FFFF);
    queue_word(ufc_pkg::CMD_QUERY, 6, 5, 32'h5555_5555);
    queue_word(ufc_pkg::CMD_EDGE, 1, 0, 32'hFFFE_FFFF);
    queue_word(ufc_pkg::CMD_QUERY, 0, 3, 32'h0);
    queue_word(ufc_pkg::CMD_EDGE, 1022, 1023, 32'h0);
    queue_word(ufc_pkg::CMD_QUERY, 1023, 1022, 32'hFFFF_FFFF);
    queue_word(ufc_pkg::CMD_EDGE, 512, 1023, 32'h5555_5555);
    queue_word(ufc_pkg::CMD_QUERY, 512, 1022, 32'h0);
    queue_word(ufc_pkg::CMD_EDGE, 6, 0, 32'hFFFF_FFFF);
    queue_word(ufc_pkg::CMD_QUERY, 5, 4, 32'h0);

    // Random part: words mostly land in a small window of nodes, so components
    // grow deep and ranks climb; the window moves every fifty words.
    pool_base = 0;
    pool_size = NODE_COUNT;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: pool_size = 8;
          1: pool_size = 32;
          2: pool_size = 128;
          default: pool_size = NODE_COUNT;
        endcase
        pool_base = $urandom_range(0, NODE_COUNT - pool_size);
      end
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, NODE_COUNT - 1);
        b = $urandom_range(0, NODE_COUNT - 1);
      end else begin
        a = pool_base + $urandom_range(0, pool_size - 1);
        b = pool_base + $urandom_range(0, pool_size - 1);
      end
      pick = $urandom_range(0, 19);
      if (pick < 14)
        w = ~((32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31)));
      else if (pick < 17)
        w = $urandom;
      else if (pick < 19)
        w = ufc_pkg::WEIGHT_ONES;
      else
        w = ufc_pkg::WEIGHT_ZERO;
      queue_word(($urandom_range(0, 4) < 2) ? ufc_pkg::CMD_QUERY : ufc_pkg::CMD_EDGE, a, b, w);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_walks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_walks.size() == 0) begin
      $display("union_find_and_cost_tb passed");
    end else begin
      $display("union_find_and_cost_tb failed");
    end
    $finish;
  end

endmodule

// ===== union_find_and_cost.f =====
+incdir+src
src/ufc_pkg.sv
src/ufc_ram.sv
src/ufc_front.sv
src/ufc_queue.sv
src/ufc_back.sv
src/union_find_and_cost.sv
verif/union_find_and_cost_tb.sv
